[rtl/boundary_tag_allocator_assert.svh]
// assertion macros used by the allocator rtl
`ifndef BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bta_pkg.sv]
// package: payload types and constants of the boundary tag allocator
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

    localparam int unsigned HEAP_WORDS_DEFAULT = 65536;
    localparam logic [15:0] MIN_REMAINDER_RESET = 16'd1000;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] request_size;
        logic [15:0] block_addr;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] result_addr;
    } out_item_t;

endpackage
`default_nettype wire

[rtl/boundary_tag_allocator.sv]
// top level: boundary tag next-fit heap allocator with a word memory sequencer
//
// Boundary tag heap manager. Each transfer on s_ is an allocate (func 0,
// request_size words including tags) or a free (func 1, header at
// block_addr); each produces exactly one result transfer on m_ with status
// (0 ok, 1 zero size or no block big enough) and the allocated header
// address (0 for a free or a failed allocate). The heap lives in one ram of
// HEAP_WORDS words, each holding link, rlink, a 32-bit size and the occupied
// tag. A small sequencer runs every step as a read-modify-write through the
// single ram port pair, each memory access a read state and then a write
// state. The cost of an allocate grows with the free-list nodes visited by
// the search walk, so it depends on fragmentation. After reset the ram is
// initialized by a clearing pass over all HEAP_WORDS words during which
// s_ready stays low; cfg writes (min_remainder) are taken at any time and
// must only be issued while the block is idle. A finished result waits in an
// output register, and the next item is accepted as soon as the sequencer is
// back in idle. HEAP_WORDS must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_allocator #(
    parameter int unsigned HEAP_WORDS = bta_pkg::HEAP_WORDS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bta_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bta_pkg::out_item_t     m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);
    import bta_pkg::*;

    `include "boundary_tag_allocator_assert.svh"

    localparam int unsigned AW = $clog2(HEAP_WORDS);
    localparam int unsigned WW = 2 * AW + 33;
    localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_WORDS - 1);
    localparam logic [AW:0]   STEP_LIMIT = (AW + 1)'(HEAP_WORDS);

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RD    = 5'b00100,
        ST_WR    = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // memory micro-operations
    typedef enum logic [4:0] {
        OP_SEARCH, OP_AW_NXT, OP_AW_PRV, OP_AW_P, OP_AW_F,
        OP_AS_F, OP_AS_P, OP_AS_F2, OP_AS_Q,
        OP_F_PREV, OP_F_SELF, OP_F_NEXT,
        OP_A_P, OP_A_FOOT, OP_A_SELF, OP_A_HEAD, OP_A_PLINK, OP_A_Q, OP_A_H,
        OP_B_S, OP_B_F,
        OP_C_P1, OP_C_Q, OP_C_P2, OP_C_Q1, OP_C_T, OP_C_P3,
        OP_D_S, OP_D_Q, OP_D_Q1,
        OP_T_FOOT, OP_FT
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] t_reg, t_next;
    logic [AW-1:0] q_reg, q_next;
    logic [AW-1:0] q1_reg, q1_next;
    logic [AW-1:0] f_reg, f_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW:0]   steps_reg, steps_next;
    logic [31:0]   n_reg, n_next;
    logic [31:0]   tsz_reg, tsz_next;
    logic          pre_reg, pre_next;
    logic          empty_reg, empty_next;
    logic [15:0]   minr_reg, minr_next;
    out_item_t     res_reg, res_next;
    out_item_t     out_reg, out_next;
    logic          mvalid_reg, mvalid_next;

    // ram ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic [WW-1:0] mem_rdata;

    // fields of the word read back
    logic [AW-1:0] w_link, w_rlink;
    logic [31:0]   w_size;
    logic          w_tag;
    // fields of the word written back
    logic [AW-1:0] n_link, n_rlink;
    logic [31:0]   n_size;
    logic          n_tag;
    logic [WW-1:0] init_word;
    logic [31:0]   spare;

    bta_ram #(
        .WIDTH (WW),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    assign w_link  = mem_rdata[AW-1:0];
    assign w_rlink = mem_rdata[2*AW-1:AW];
    assign w_size  = mem_rdata[2*AW+31:2*AW];
    assign w_tag   = mem_rdata[WW-1];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = mvalid_reg;
    assign m_data    = out_reg;

    // initial heap: guards at both ends, one free block linked to itself
    always_comb begin
        init_word = '0;
        if (clr_reg == '0 || clr_reg == LAST_ADDR) begin
            init_word = {1'b1, 32'd1, {AW{1'b0}}, {AW{1'b0}}};
        end else if (clr_reg == AW'(1)) begin
            init_word = {1'b0, 32'(HEAP_WORDS - 2), AW'(1), AW'(1)};
        end else if (clr_reg == LAST_ADDR - AW'(1)) begin
            init_word = {1'b0, 32'd0, {AW{1'b0}}, AW'(1)};
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        p_next      = p_reg;
        s_next      = s_reg;
        t_next      = t_reg;
        q_next      = q_reg;
        q1_next     = q1_reg;
        f_next      = f_reg;
        head_next   = head_reg;
        clr_next    = clr_reg;
        steps_next  = steps_reg;
        n_next      = n_reg;
        tsz_next    = tsz_reg;
        pre_next    = pre_reg;
        empty_next  = empty_reg;
        minr_next   = minr_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        n_link      = w_link;
        n_rlink     = w_rlink;
        n_size      = w_size;
        n_tag       = w_tag;
        spare       = w_size - n_reg;

        if (cfg_valid) begin
            minr_next = cfg_data;
        end
        if (m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    res_next = '{status: STATUS_OK, result_addr: 16'd0};
                    if (s_data.func == FUNC_ALLOC) begin
                        n_next     = 32'(s_data.request_size);
                        p_next     = head_reg;
                        addr_next  = head_reg;
                        steps_next = '0;
                        op_next    = OP_SEARCH;
                        if (s_data.request_size == 16'd0 || empty_reg) begin
                            res_next.status = STATUS_FAIL;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_RD;
                        end
                    end else begin
                        p_next     = AW'(s_data.block_addr);
                        addr_next  = AW'(s_data.block_addr) - AW'(1);
                        op_next    = OP_F_PREV;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                state_next = ST_RD;
                case (op_reg)
                    // next-fit walk of the free list, starting at the roving head
                    OP_SEARCH: begin
                        if (w_size < n_reg && w_rlink != head_reg && steps_reg < STEP_LIMIT) begin
                            addr_next  = w_rlink;
                            p_next     = w_rlink;
                            steps_next = steps_reg + (AW + 1)'(1);
                        end else if (w_size < n_reg) begin
                            res_next.status = STATUS_FAIL;
                            state_next      = ST_DONE;
                        end else begin
                            f_next    = p_reg + w_size[AW-1:0] - AW'(1);
                            t_next    = w_rlink;
                            q_next    = w_link;
                            head_next = w_rlink;
                            if (spare <= 32'(minr_reg)) begin
                                if (w_rlink == p_reg) begin
                                    empty_next = 1'b1;
                                    op_next    = OP_AW_P;
                                    addr_next  = p_reg;
                                end else begin
                                    op_next   = OP_AW_NXT;
                                    addr_next = w_rlink;
                                end
                            end else begin
                                op_next   = OP_AS_F;
                                addr_next = p_reg + w_size[AW-1:0] - AW'(1);
                            end
                        end
                    end
                    // whole block: unlink, then tag header and footer
                    OP_AW_NXT: begin
                        mem_we    = 1'b1;
                        n_link    = q_reg;
                        op_next   = OP_AW_PRV;
                        addr_next = q_reg;
                    end
                    OP_AW_PRV: begin
                        mem_we    = 1'b1;
                        n_rlink   = t_reg;
                        op_next   = OP_AW_P;
                        addr_next = p_reg;
                    end
                    OP_AW_P: begin
                        mem_we    = 1'b1;
                        n_tag     = 1'b1;
                        op_next   = OP_AW_F;
                        addr_next = f_reg;
                    end
                    OP_AW_F: begin
                        mem_we     = 1'b1;
                        n_tag      = 1'b1;
                        res_next.result_addr = 16'(p_reg);
                        state_next = ST_DONE;
                    end
                    // split: top part handed out
                    OP_AS_F: begin
                        mem_we    = 1'b1;
                        n_tag     = 1'b1;
                        op_next   = OP_AS_P;
                        addr_next = p_reg;
                    end
                    OP_AS_P: begin
                        mem_we    = 1'b1;
                        n_size    = spare;
                        op_next   = OP_AS_F2;
                        addr_next = p_reg + spare[AW-1:0] - AW'(1);
                    end
                    OP_AS_F2: begin
                        mem_we    = 1'b1;
                        n_tag     = 1'b0;
                        n_link    = p_reg;
                        op_next   = OP_AS_Q;
                        addr_next = addr_reg + AW'(1);
                    end
                    OP_AS_Q: begin
                        mem_we     = 1'b1;
                        n_tag      = 1'b1;
                        n_size     = n_reg;
                        res_next.result_addr = 16'(addr_reg);
                        state_next = ST_DONE;
                    end
                    // free: look at both neighbors first
                    OP_F_PREV: begin
                        pre_next  = w_tag;
                        s_next    = w_link;
                        op_next   = OP_F_SELF;
                        addr_next = p_reg;
                    end
                    OP_F_SELF: begin
                        n_next    = w_size;
                        t_next    = p_reg + w_size[AW-1:0];
                        op_next   = OP_F_NEXT;
                        addr_next = p_reg + w_size[AW-1:0];
                    end
                    OP_F_NEXT: begin
                        q_next   = w_link;
                        q1_next  = w_rlink;
                        tsz_next = w_size;
                        if (pre_reg && w_tag) begin
                            op_next   = OP_A_P;
                            addr_next = p_reg;
                        end else if (w_tag) begin
                            op_next   = OP_B_S;
                            addr_next = s_reg;
                        end else if (pre_reg) begin
                            s_next    = p_reg;
                            op_next   = OP_C_P1;
                            addr_next = p_reg;
                        end else begin
                            op_next   = OP_D_S;
                            addr_next = s_reg;
                        end
                    end
                    // no free neighbor: insert before the head
                    OP_A_P: begin
                        mem_we    = 1'b1;
                        n_tag     = 1'b0;
                        op_next   = OP_A_FOOT;
                        addr_next = p_reg + w_size[AW-1:0] - AW'(1);
                    end
                    OP_A_FOOT: begin
                        mem_we = 1'b1;
                        n_link = p_reg;
                        n_tag  = 1'b0;
                        if (empty_reg) begin
                            op_next   = OP_A_SELF;
                            addr_next = p_reg;
                        end else begin
                            op_next   = OP_A_HEAD;
                            addr_next = head_reg;
                        end
                    end
                    OP_A_SELF: begin
                        mem_we     = 1'b1;
                        n_link     = p_reg;
                        n_rlink    = p_reg;
                        empty_next = 1'b0;
                        head_next  = p_reg;
                        state_next = ST_DONE;
                    end
                    OP_A_HEAD: begin
                        q_next    = w_link;
                        op_next   = OP_A_PLINK;
                        addr_next = p_reg;
                    end
                    OP_A_PLINK: begin
                        mem_we    = 1'b1;
                        n_rlink   = head_reg;
                        n_link    = q_reg;
                        op_next   = OP_A_Q;
                        addr_next = q_reg;
                    end
                    OP_A_Q: begin
                        mem_we    = 1'b1;
                        n_rlink   = p_reg;
                        op_next   = OP_A_H;
                        addr_next = head_reg;
                    end
                    OP_A_H: begin
                        mem_we     = 1'b1;
                        n_link     = p_reg;
                        head_next  = p_reg;
                        state_next = ST_DONE;
                    end
                    // merge into the lower neighbor
                    OP_B_S: begin
                        mem_we    = 1'b1;
                        n_size    = w_size + n_reg;
                        op_next   = OP_B_F;
                        addr_next = p_reg + n_reg[AW-1:0] - AW'(1);
                    end
                    OP_B_F: begin
                        mem_we     = 1'b1;
                        n_link     = s_reg;
                        n_tag      = 1'b0;
                        state_next = ST_DONE;
                    end
                    // absorb the upper neighbor, taking its list place
                    OP_C_P1: begin
                        mem_we    = 1'b1;
                        n_tag     = 1'b0;
                        n_link    = q_reg;
                        op_next   = OP_C_Q;
                        addr_next = q_reg;
                    end
                    OP_C_Q: begin
                        mem_we    = 1'b1;
                        n_rlink   = p_reg;
                        op_next   = OP_C_P2;
                        addr_next = p_reg;
                    end
                    OP_C_P2: begin
                        mem_we    = 1'b1;
                        n_rlink   = q1_reg;
                        op_next   = OP_C_Q1;
                        addr_next = q1_reg;
                    end
                    OP_C_Q1: begin
                        mem_we    = 1'b1;
                        n_link    = p_reg;
                        op_next   = OP_C_T;
                        addr_next = t_reg;
                    end
                    OP_C_T: begin
                        tsz_next  = w_size;
                        op_next   = OP_C_P3;
                        addr_next = p_reg;
                    end
                    OP_C_P3: begin
                        mem_we    = 1'b1;
                        n_size    = w_size + tsz_reg;
                        op_next   = OP_T_FOOT;
                        addr_next = t_reg;
                    end
                    // both neighbors free: upper one leaves the list
                    OP_D_S: begin
                        mem_we    = 1'b1;
                        n_size    = w_size + n_reg + tsz_reg;
                        op_next   = OP_D_Q;
                        addr_next = q_reg;
                    end
                    OP_D_Q: begin
                        mem_we    = 1'b1;
                        n_rlink   = q1_reg;
                        op_next   = OP_D_Q1;
                        addr_next = q1_reg;
                    end
                    OP_D_Q1: begin
                        mem_we    = 1'b1;
                        n_link    = q_reg;
                        op_next   = OP_T_FOOT;
                        addr_next = t_reg;
                    end
                    // footer of the upper block points at the merged block
                    OP_T_FOOT: begin
                        op_next   = OP_FT;
                        addr_next = t_reg + w_size[AW-1:0] - AW'(1);
                    end
                    OP_FT: begin
                        mem_we = 1'b1;
                        n_link = s_reg;
                        if (head_reg == t_reg) begin
                            head_next = s_reg;
                        end
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    out_next    = res_reg;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        mem_wdata = (state_reg == ST_CLEAR) ? init_word : {n_tag, n_size, n_rlink, n_link};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            op_reg     <= OP_SEARCH;
            clr_reg    <= '0;
            head_reg   <= AW'(1);
            empty_reg  <= 1'b0;
            minr_reg   <= MIN_REMAINDER_RESET;
            mvalid_reg <= 1'b0;
            steps_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            empty_reg  <= empty_next;
            minr_reg   <= minr_next;
            mvalid_reg <= mvalid_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        p_reg    <= p_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        q_reg    <= q_next;
        q1_reg   <= q1_next;
        f_reg    <= f_next;
        n_reg    <= n_next;
        tsz_reg  <= tsz_next;
        pre_reg  <= pre_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    `BTA_ASSERT_NOW(a_fail_addr_zero, aclk, aresetn, m_valid && m_data.status == STATUS_FAIL, m_data.result_addr == 16'd0, "failed allocate carries a nonzero address")
    `BTA_ASSERT_NOW(a_no_write_on_rd, aclk, aresetn, state_reg == ST_RD, !mem_we, "heap written during a read cycle")
    `BTA_ASSERT_NOW(a_steps_bounded, aclk, aresetn, state_reg == ST_WR && op_reg == OP_SEARCH, steps_reg <= STEP_LIMIT, "search walked past the heap size")
    `BTA_ASSERT_NEXT(a_clear_leaves_list, aclk, aresetn, state_reg == ST_CLEAR && clr_reg == LAST_ADDR, state_reg == ST_IDLE && !empty_reg && head_reg == AW'(1), "heap init did not end with one free block")

endmodule
`default_nettype wire

[rtl/bta_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module bta_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[test/tb_top.sv]
// testbench for the boundary tag allocator, with its own heap predictor and a result checker
`timescale 1ns / 1ps
module tb_top;
    import bta_pkg::*;

    localparam int unsigned HW          = 65536;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned SETTLE      = 40;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [15:0] cfg_data;

    boundary_tag_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // heap predictor: its own copy of every word, the head and the
    // configured leftover limit
    // ---------------------------------------------------------------
    bit [31:0]   w_link  [HW];
    bit [31:0]   w_rlink [HW];
    bit [31:0]   w_size  [HW];
    bit          w_tag   [HW];
    bit [15:0]   rover;
    bit          heap_full;
    bit [15:0]   leftover_limit;

    out_item_t   pending_results[$];
    bit [15:0]   live_blocks[$];
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned alloc_count;
    int unsigned free_count;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned rx_hold;
    bit          quiet;

    function automatic void heap_reset();
        for (int i = 0; i < HW; i++) begin
            w_link[i] = 0;
            w_rlink[i] = 0;
            w_size[i] = 0;
            w_tag[i] = 1'b0;
        end
        w_tag[0] = 1'b1;
        w_size[0] = 1;
        w_tag[HW-1] = 1'b1;
        w_size[HW-1] = 1;
        w_size[1] = HW - 2;
        w_link[1] = 1;
        w_rlink[1] = 1;
        w_link[HW-2] = 1;
        rover = 16'd1;
        heap_full = 1'b0;
        leftover_limit = MIN_REMAINDER_RESET;
    endfunction

    // footer address of the block whose header is at p
    function automatic bit [15:0] foot_of(bit [15:0] p);
        return p + w_size[p][15:0] - 16'd1;
    endfunction

    function automatic out_item_t heap_alloc(bit [15:0] n);
        out_item_t   r;
        bit [15:0]   p;
        bit [15:0]   f;
        bit [15:0]   nxt;
        bit [15:0]   prv;
        bit [15:0]   q;
        int unsigned steps;
        r.status = STATUS_FAIL;
        r.result_addr = '0;
        steps = 0;
        if (n == 0 || heap_full) return r;
        p = rover;
        while (w_size[p] < n && w_rlink[p][15:0] != rover && steps < HW) begin
            p = w_rlink[p][15:0];
            steps++;
        end
        if (w_size[p] < n) return r;
        f = foot_of(p);
        nxt = w_rlink[p][15:0];
        rover = nxt;
        if (w_size[p] - n <= {16'd0, leftover_limit}) begin
            // whole block goes out, unlink it
            if (nxt == p) begin
                heap_full = 1'b1;
            end else begin
                prv = w_link[p][15:0];
                w_link[nxt] = prv;
                w_rlink[prv] = nxt;
            end
            w_tag[p] = 1'b1;
            w_tag[f] = 1'b1;
            q = p;
        end else begin
            // hand out the top part, the bottom stays on the list
            w_tag[f] = 1'b1;
            w_size[p] = w_size[p] - n;
            f = foot_of(p);
            w_tag[f] = 1'b0;
            w_link[f] = p;
            q = f + 16'd1;
            w_tag[q] = 1'b1;
            w_size[q] = n;
        end
        r.status = STATUS_OK;
        r.result_addr = q;
        return r;
    endfunction

    function automatic void heap_free(bit [15:0] p);
        bit        below_used;
        bit        above_used;
        bit [15:0] f;
        bit [15:0] s;
        bit [15:0] t;
        bit [15:0] q;
        bit [15:0] q1;
        bit [15:0] h;
        bit [31:0] n;
        below_used = w_tag[p - 16'd1];
        above_used = w_tag[p + w_size[p][15:0]];
        n = w_size[p];
        if (below_used && above_used) begin
            // no free neighbor: insert in front of the head
            w_tag[p] = 1'b0;
            f = foot_of(p);
            w_link[f] = p;
            w_tag[f] = 1'b0;
            if (heap_full) begin
                w_link[p] = p;
                w_rlink[p] = p;
                heap_full = 1'b0;
            end else begin
                h = rover;
                q = w_link[h][15:0];
                w_rlink[p] = h;
                w_link[p] = q;
                w_rlink[q] = p;
                w_link[h] = p;
            end
            rover = p;
        end else if (!below_used && above_used) begin
            // grow the free block below
            s = w_link[p - 16'd1][15:0];
            f = p + n[15:0] - 16'd1;
            w_size[s] = w_size[s] + n;
            w_link[f] = s;
            w_tag[f] = 1'b0;
        end else if (below_used && !above_used) begin
            // absorb the free block above, taking its list place
            t = p + w_size[p][15:0];
            q = w_link[t][15:0];
            q1 = w_rlink[t][15:0];
            w_tag[p] = 1'b0;
            w_link[p] = q;
            w_rlink[q] = p;
            w_rlink[p] = q1;
            w_link[q1] = p;
            w_size[p] = w_size[p] + w_size[t];
            w_link[foot_of(t)] = p;
            if (rover == t) rover = p;
        end else begin
            // both sides free: everything folds into the lower block
            s = w_link[p - 16'd1][15:0];
            t = p + n[15:0];
            q = w_link[t][15:0];
            q1 = w_rlink[t][15:0];
            w_size[s] = w_size[s] + n + w_size[t];
            w_rlink[q] = q1;
            w_link[q1] = q;
            w_link[foot_of(t)] = s;
            if (rover == t) rover = s;
        end
    endfunction

    function automatic out_item_t predict_item(in_item_t it);
        out_item_t r;
        if (it.func == FUNC_ALLOC) begin
            r = heap_alloc(it.request_size);
        end else begin
            heap_free(it.block_addr);
            r.status = STATUS_OK;
            r.result_addr = '0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // run limit
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // result side: random stalls, long hold-off on request, checking
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: status %0d addr %0d",
                           m_data.status, m_data.result_addr);
                    mismatch_count++;
                end else begin
                    exp_item = pending_results.pop_front();
                    if (m_data.status !== exp_item.status) begin
                        $error("status: expected %0d actual %0d",
                               exp_item.status, m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.result_addr !== exp_item.result_addr) begin
                        $error("result_addr: expected %0d actual %0d",
                               exp_item.result_addr, m_data.result_addr);
                        mismatch_count++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    task automatic send_item(input in_item_t it, output out_item_t res);
        if (!quiet && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // transfer taken at this edge
        res = predict_item(it);
        pending_results.push_back(res);
        if (it.func == FUNC_ALLOC) alloc_count++;
        else free_count++;
        if (it.func == FUNC_ALLOC && res.status == STATUS_FAIL) fail_count++;
    endtask

    task automatic release_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic alloc_words(input bit [15:0] n, output bit [15:0] addr);
        in_item_t  it;
        out_item_t res;
        it.func = FUNC_ALLOC;
        it.request_size = n;
        it.block_addr = 16'($urandom);
        send_item(it, res);
        addr = res.result_addr;
        if (res.status == STATUS_OK) live_blocks.push_back(res.result_addr);
    endtask

    task automatic free_block(input bit [15:0] addr);
        in_item_t  it;
        out_item_t res;
        it.func = FUNC_FREE;
        it.request_size = 16'($urandom);
        it.block_addr = addr;
        send_item(it, res);
        foreach (live_blocks[i]) begin
            if (live_blocks[i] == addr) begin
                live_blocks.delete(i);
                break;
            end
        end
    endtask

    // sender stops until every expected result is back
    task automatic drain();
        release_input();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_leftover_limit(input bit [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        leftover_limit = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        bit [15:0] a;
        bit [15:0] b;
        bit [15:0] c;
        bit [15:0] d;
        alloc_words(16'd0, a);        // zero request fails
        alloc_words(16'hFFFF, a);     // larger than the whole heap
        alloc_words(16'hFFFE, a);     // takes the whole heap, list goes empty
        alloc_words(16'd5, b);        // empty list fails
        free_block(a);                // back onto an empty list
        alloc_words(16'd100, a);
        alloc_words(16'd200, b);
        alloc_words(16'd1, c);        // one-word block
        alloc_words(16'd3000, d);
        free_block(a);                // both neighbors occupied
        free_block(b);                // merges with the block above, head moves
        free_block(d);                // merges with the free block below
        free_block(c);                // free on both sides
        alloc_words(16'd64000, a);    // leftover above the limit: split, top part handed out
        alloc_words(16'd2, b);
        free_block(a);
        alloc_words(16'd20000, a);
        alloc_words(16'd30000, c);
        alloc_words(16'd40000, d);    // no fit anywhere
        free_block(c);
        free_block(b);
        free_block(a);
        drain();
    endtask

    task automatic random_mix(input int unsigned count);
        bit [15:0]   addr;
        bit [15:0]   n;
        int unsigned pick;
        for (int unsigned k = 0; k < count; k++) begin
            if (live_blocks.size() != 0 &&
                ($urandom_range(99) < 45 || live_blocks.size() > 40)) begin
                pick = $urandom_range(live_blocks.size() - 1);
                free_block(live_blocks[pick]);
            end else begin
                pick = $urandom_range(99);
                if (pick < 80) n = 16'($urandom_range(1, 64));
                else if (pick < 95) n = 16'($urandom_range(65, 4000));
                else n = 16'($urandom_range(4001, 65535));
                alloc_words(n, addr);
            end
        end
    endtask

    task automatic test_settings();
        write_leftover_limit(16'd1000);
        random_mix(120);
        write_leftover_limit(16'd0);
        random_mix(120);
        write_leftover_limit(16'hFFFF);
        random_mix(50);
        write_leftover_limit(16'($urandom_range(1, 65534)));
        random_mix(80);
        write_leftover_limit(16'd16);
        random_mix(120);
        drain();
    endtask

    task automatic test_backpressure();
        // result side holds for a long stretch while items keep coming
        quiet = 1'b1;
        rx_hold = 400;
        random_mix(20);
        release_input();
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_quiet_stretch();
        quiet = 1'b1;
        random_mix(80);
        quiet = 1'b0;
        drain();
    endtask

    // a double free and frees of arbitrary addresses, then two allocates
    task automatic test_bad_frees();
        bit [15:0] addr;
        if (live_blocks.size() != 0) begin
            addr = live_blocks[0];
            free_block(addr);
            free_block(addr);         // double free
        end
        free_block(16'($urandom));
        free_block(16'hFFFF);
        free_block(16'h0000);
        live_blocks.delete();
        alloc_words(16'd7, addr);
        alloc_words(16'($urandom_range(1, 65535)), addr);
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_ready = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        alloc_count = 0;
        free_count = 0;
        fail_count = 0;
        cycle_count = 0;
        rx_hold = 0;
        quiet = 1'b0;
        heap_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_settings();
        test_backpressure();
        test_quiet_stretch();
        random_mix(40);
        drain();
        test_bad_frees();

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("covered %0d allocates (%0d refused) and %0d frees, %0d results checked",
                 alloc_count, fail_count, free_count, result_count);
        $display("leftover limits 0, 16, 1000, max and random; stalls, hold-off, bad frees");
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[boundary_tag_allocator.f]
+incdir+rtl
rtl/bta_pkg.sv
rtl/bta_ram.sv
rtl/boundary_tag_allocator.sv
test/tb_top.sv
